// ===== src/ppsm_pkg.sv =====
// Shared types, constants and helpers of the PPS phase offset meter.
package ppsm_pkg;

  localparam int NUM_SOURCES = 5;
  localparam int IDX_W       = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int SRC_W       = 3;
  localparam int SEC_W       = 48;
  localparam int NS_W        = 30;
  localparam int OFF_W       = 31;
  localparam int ACC_W       = 48;

  localparam logic [NS_W-1:0]         WINDOW_RESET = NS_W'(500 * 1000 * 1000);
  localparam logic signed [ACC_W-1:0] NS_1S        = ACC_W'(1000 * 1000 * 1000);
  localparam logic signed [ACC_W-1:0] SEC_GAP_MAX  = ACC_W'(3);

  typedef enum logic [1:0] {
    STAT_UPDATED       = 2'd0,
    STAT_OUT_OF_WINDOW = 2'd1,
    STAT_NEG_SECONDS   = 2'd2,
    STAT_UNKNOWN_SRC   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PICK,
    S_LOAD,
    S_SECS,
    S_NSADD,
    S_NSSUB,
    S_JUDGE,
    S_EMIT
  } state_e;

  // Step control of the shared add/subtract unit.
  typedef struct packed {
    logic sec_diff;
    logic ns_add;
    logic ns_sub;
  } dp_ctrl_t;

  typedef struct packed {
    logic sec_ok;
    logic in_window;
  } dp_status_t;

  // Seconds gap in the range -3..3 scaled to nanoseconds.
  function automatic logic signed [ACC_W-1:0] sec_to_ns(input logic [2:0] gap);
    logic signed [ACC_W-1:0] r;
    case (gap)
      3'b001:  r = NS_1S;
      3'b010:  r = NS_1S + NS_1S;
      3'b011:  r = NS_1S + NS_1S + NS_1S;
      3'b111:  r = -NS_1S;
      3'b110:  r = -(NS_1S + NS_1S);
      3'b101:  r = -(NS_1S + NS_1S + NS_1S);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/pps_phase_offset_meter.sv =====
// Top level of the PPS phase offset meter: stamp stores, sequencer and output register.
//
// Usage: each input request carries a source index, seconds and nanoseconds of a
// pulse-per-second stamp; it is taken when in_valid_i is high and in_stall_o low.
// Sources 0..4 are external inputs, source 5 is the local reference clock.
// A negative-seconds or unknown-index request yields one reject result at once.
// An external request re-evaluates its own source; a reference request walks all
// external sources. Only sources with both stamps present yield a result, so a
// request may yield zero to five results; last_result_o marks the final one.
// The block takes one request at a time. Each evaluated source passes through the
// steps of the shared add/subtract unit (pick, read, seconds difference, scale and
// add, subtract, judge, emit). Receiver stall holds the output register and the
// sequencer waits in its emit step; the input stays stalled.
// Configuration: window_ns is written through cfg_valid_i/cfg_data_i, always ready.
// The user must write it only while the block is idle; the block does not enforce this.
// Reset clears all received flags, ready flags and kept offsets, and loads the
// window with 500 ms.
module pps_phase_offset_meter import ppsm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [NS_W-1:0]         cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [SRC_W-1:0]        source_index_i,
  input  logic signed [SEC_W-1:0] stamp_seconds_i,
  input  logic [NS_W-1:0]         stamp_nanoseconds_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [SRC_W-1:0]        result_source_o,
  output logic [1:0]              status_o,
  output logic signed [OFF_W-1:0] phase_offset_ns_o,
  output logic                    offset_ready_o,
  output logic                    last_result_o
);

  localparam logic [IDX_W-1:0] LAST_SRC = IDX_W'(NUM_SOURCES - 1);

  state_e state_q, state_d;

  logic [NS_W-1:0]         window_q;
  logic [IDX_W-1:0]        src_q, src_d;
  logic                    scan_all_q, scan_all_d;
  logic                    reject_q, reject_d;
  logic [SRC_W-1:0]        idx_q, idx_d;
  status_e                 stat_q, stat_d;

  logic [NUM_SOURCES-1:0]  rcv_q;
  logic                    ref_rcv_q;
  logic signed [SEC_W-1:0] ref_sec_q;
  logic [NS_W-1:0]         ref_ns_q;

  // External stamp memory, one entry per source.
  logic signed [SEC_W-1:0] mem_sec [NUM_SOURCES];
  logic [NS_W-1:0]         mem_ns  [NUM_SOURCES];
  logic signed [SEC_W-1:0] rd_sec_q;
  logic [NS_W-1:0]         rd_ns_q;

  logic signed [OFF_W-1:0] offset_q [NUM_SOURCES];
  logic [NUM_SOURCES-1:0]  ready_q;

  logic                    out_valid_q;
  logic [SRC_W-1:0]        out_src_q;
  status_e                 out_stat_q;
  logic signed [OFF_W-1:0] out_off_q;
  logic                    out_rdy_q;
  logic                    out_last_q;

  logic                    accept, neg_sec, unknown_src, is_ref;
  logic                    hit, at_last, higher_rcv, res_last;
  logic                    out_free, out_load, advance, judge_wr;
  dp_ctrl_t                dp_ctrl;
  dp_status_t              dp_stat;
  logic signed [ACC_W-1:0] acc;

  assign accept      = in_valid_i && !in_stall_o;
  assign neg_sec     = stamp_seconds_i[SEC_W-1];
  assign unknown_src = source_index_i > SRC_W'(NUM_SOURCES);
  assign is_ref      = source_index_i == SRC_W'(NUM_SOURCES);
  assign hit         = rcv_q[src_q] && ref_rcv_q;
  assign at_last     = src_q == LAST_SRC;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;

  // A scan result is final when no later source has a stamp.
  always_comb begin
    higher_rcv = 1'b0;
    for (int t = 0; t < NUM_SOURCES; t++) begin
      if ((IDX_W'(t) > src_q) && rcv_q[t]) begin
        higher_rcv = 1'b1;
      end
    end
    res_last = reject_q || !scan_all_q || !higher_rcv;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (neg_sec || unknown_src) ? S_EMIT : S_PICK;
        end
      end
      S_PICK: begin
        if (hit) begin
          state_d = S_LOAD;
        end else if (!(scan_all_q && !at_last)) begin
          state_d = S_IDLE;
        end
      end
      S_LOAD:  state_d = S_SECS;
      S_SECS:  state_d = S_NSADD;
      S_NSADD: state_d = S_NSSUB;
      S_NSSUB: state_d = S_JUDGE;
      S_JUDGE: state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_d = (reject_q || !scan_all_q || at_last) ? S_IDLE : S_PICK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    dp_ctrl  = '0;
    out_load = 1'b0;
    advance  = 1'b0;
    judge_wr = 1'b0;
    case (state_q)
      S_PICK:  advance = !hit && scan_all_q && !at_last;
      S_SECS:  dp_ctrl.sec_diff = 1'b1;
      S_NSADD: dp_ctrl.ns_add = 1'b1;
      S_NSSUB: dp_ctrl.ns_sub = 1'b1;
      S_JUDGE: judge_wr = 1'b1;
      S_EMIT: begin
        out_load = out_free;
        advance  = out_free && !reject_q && scan_all_q && !at_last;
      end
      default: ;
    endcase
  end

  // Request bookkeeping.
  always_comb begin
    src_d      = src_q;
    scan_all_d = scan_all_q;
    reject_d   = reject_q;
    idx_d      = idx_q;
    stat_d     = stat_q;
    if (accept) begin
      idx_d      = source_index_i;
      reject_d   = neg_sec || unknown_src;
      scan_all_d = is_ref;
      src_d      = is_ref ? '0 : source_index_i[IDX_W-1:0];
      stat_d     = neg_sec ? STAT_NEG_SECONDS : STAT_UNKNOWN_SRC;
    end else if (advance) begin
      src_d = src_q + IDX_W'(1);
    end else if (judge_wr) begin
      stat_d = dp_stat.in_window ? STAT_UPDATED : STAT_OUT_OF_WINDOW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      window_q    <= WINDOW_RESET;
      src_q       <= '0;
      scan_all_q  <= 1'b0;
      reject_q    <= 1'b0;
      rcv_q       <= '0;
      ref_rcv_q   <= 1'b0;
      ready_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        offset_q[i] <= '0;
      end
    end else begin
      state_q    <= state_d;
      src_q      <= src_d;
      scan_all_q <= scan_all_d;
      reject_q   <= reject_d;
      if (cfg_valid_i && cfg_ready_o) begin
        window_q <= cfg_data_i;
      end
      // Mark the stamp as received once a good request lands.
      if (accept && !neg_sec && !unknown_src) begin
        if (is_ref) begin
          ref_rcv_q <= 1'b1;
        end else begin
          rcv_q[source_index_i[IDX_W-1:0]] <= 1'b1;
        end
      end
      // Keep the offset only when in window; otherwise drop the ready flag.
      if (judge_wr) begin
        ready_q[src_q] <= dp_stat.in_window;
        if (dp_stat.in_window) begin
          offset_q[src_q] <= acc[OFF_W-1:0];
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    stat_q <= stat_d;
    if (accept && !neg_sec && !unknown_src) begin
      if (is_ref) begin
        ref_sec_q <= stamp_seconds_i;
        ref_ns_q  <= stamp_nanoseconds_i;
      end else begin
        mem_sec[source_index_i[IDX_W-1:0]] <= stamp_seconds_i;
        mem_ns[source_index_i[IDX_W-1:0]]  <= stamp_nanoseconds_i;
      end
    end
    if (state_q == S_LOAD) begin
      rd_sec_q <= mem_sec[src_q];
      rd_ns_q  <= mem_ns[src_q];
    end
    if (out_load) begin
      out_stat_q <= stat_q;
      out_last_q <= res_last;
      if (reject_q) begin
        out_src_q <= idx_q;
        out_off_q <= '0;
        out_rdy_q <= 1'b0;
      end else begin
        out_src_q <= SRC_W'(src_q);
        out_off_q <= offset_q[src_q];
        out_rdy_q <= ready_q[src_q];
      end
    end
  end

  ppsm_datapath u_datapath (
    .clk_i     (clk_i),
    .ctrl_i    (dp_ctrl),
    .sec_src_i (rd_sec_q),
    .ns_src_i  (rd_ns_q),
    .sec_ref_i (ref_sec_q),
    .ns_ref_i  (ref_ns_q),
    .window_i  (window_q),
    .acc_o     (acc),
    .status_o  (dp_stat)
  );

  assign out_valid_o       = out_valid_q;
  assign result_source_o   = out_src_q;
  assign status_o          = out_stat_q;
  assign phase_offset_ns_o = out_off_q;
  assign offset_ready_o    = out_rdy_q;
  assign last_result_o     = out_last_q;

  // An updated offset is always reported as ready.
  a_updated_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_UPDATED) |-> offset_ready_o)
    else $error("updated result without ready flag");

  // An out-of-window result always reports a cleared ready flag.
  a_oow_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_OUT_OF_WINDOW) |-> !offset_ready_o)
    else $error("out-of-window result with ready flag set");

  // A reject is a single final result with a cleared payload.
  a_reject_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == STAT_NEG_SECONDS) || (status_o == STAT_UNKNOWN_SRC))
    |-> last_result_o && !offset_ready_o && (phase_offset_ns_o == '0))
    else $error("malformed reject result");

  // Once a request is taken the input stalls until the sequencer is done.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a request was taken");

endmodule

// ===== src/ppsm_datapath.sv =====
// Shared add/subtract unit with accumulator and window compare.
module ppsm_datapath import ppsm_pkg::*; (
  input  logic                    clk_i,
  input  dp_ctrl_t                ctrl_i,
  input  logic signed [SEC_W-1:0] sec_src_i,
  input  logic [NS_W-1:0]         ns_src_i,
  input  logic signed [SEC_W-1:0] sec_ref_i,
  input  logic [NS_W-1:0]         ns_ref_i,
  input  logic [NS_W-1:0]         window_i,
  output logic signed [ACC_W-1:0] acc_o,
  output dp_status_t              status_o
);

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic                    sec_ok_q, sec_ok_d;
  logic signed [ACC_W-1:0] op_a, op_b, sum;
  logic signed [ACC_W-1:0] win_ext;
  logic                    do_sub;

  always_comb begin
    op_a   = acc_q;
    op_b   = $signed(ACC_W'(ns_ref_i));
    do_sub = 1'b1;
    if (ctrl_i.sec_diff) begin
      op_a   = ACC_W'(sec_src_i);
      op_b   = ACC_W'(sec_ref_i);
      do_sub = 1'b1;
    end else if (ctrl_i.ns_add) begin
      op_a   = sec_to_ns(acc_q[2:0]);
      op_b   = $signed(ACC_W'(ns_src_i));
      do_sub = 1'b0;
    end
    sum = do_sub ? (op_a - op_b) : (op_a + op_b);
  end

  always_comb begin
    acc_d    = acc_q;
    sec_ok_d = sec_ok_q;
    if (ctrl_i.sec_diff || ctrl_i.ns_add || ctrl_i.ns_sub) begin
      acc_d = sum;
    end
    // Judge the seconds gap before it is replaced by the scaled value.
    if (ctrl_i.ns_add) begin
      sec_ok_d = (acc_q <= SEC_GAP_MAX) && (acc_q >= -SEC_GAP_MAX);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    sec_ok_q <= sec_ok_d;
  end

  assign win_ext            = $signed(ACC_W'(window_i));
  assign acc_o              = acc_q;
  assign status_o.sec_ok    = sec_ok_q;
  assign status_o.in_window = sec_ok_q && (acc_q <= win_ext) && (acc_q >= -win_ext);

endmodule

// ===== tb/pps_phase_offset_meter_tb.sv =====
// Self-checking testbench of the PPS phase offset meter with its own offset predictor.
module pps_phase_offset_meter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ppsm_pkg::*;

  // Source index of the local reference clock.
  localparam int REF_SRC = NUM_SOURCES;
  // Cycles to let pass after the last result: a reference request that
  // evaluates nothing may still be walking the sources.
  localparam int SETTLE_CYCLES = 48;
  localparam logic [NS_W-1:0] NS_TOP = NS_W'(999999999);
  localparam logic [NS_W-1:0] NS_ONES = '1;
  localparam logic [SEC_W-1:0] SEC_TOP = {1'b0, {(SEC_W-1){1'b1}}};
  localparam logic [SEC_W-1:0] SEC_NEG_MIN = {1'b1, {(SEC_W-1){1'b0}}};

  typedef struct {
    logic [SRC_W-1:0] src;
    status_e status;
    logic signed [OFF_W-1:0] offset;
    logic ready;
    logic last;
  } offset_report_t;

  // Clock, reset and the stimulus side of the ports.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic [NS_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic [SRC_W-1:0] in_src = '0;
  logic [SEC_W-1:0] in_sec = '0;
  logic [NS_W-1:0] in_ns = '0;
  logic out_stall = 1'b0;

  logic cfg_ready;
  logic in_stall;
  logic out_valid;
  logic [SRC_W-1:0] res_src;
  logic [1:0] res_status;
  logic signed [OFF_W-1:0] res_offset;
  logic res_ready;
  logic res_last;

  // Predictor copy of the meter's state.
  logic [SEC_W-1:0] held_sec [0:NUM_SOURCES];
  logic [NS_W-1:0] held_ns [0:NUM_SOURCES];
  bit held_valid [0:NUM_SOURCES];
  logic signed [OFF_W-1:0] kept_offset [0:NUM_SOURCES-1];
  bit kept_ready [0:NUM_SOURCES-1];
  logic [NS_W-1:0] window = WINDOW_RESET;

  // Reports the meter still owes, oldest first.
  offset_report_t reports_due[$];

  // Traffic shaping shared by the sender, the receiver and the tests.
  bit no_idle = 1'b0;
  bit valid_up = 1'b0;
  int next_gap = 0;
  int stall_left = 0;
  int hold_cycles = 0;
  logic [SEC_W-1:0] sec_base = SEC_W'(1000);

  // Run statistics.
  int errors = 0;
  int requests_sent = 0;
  int ref_requests = 0;
  int results_seen = 0;
  int updated_seen = 0;
  int out_window_seen = 0;
  int rejects_seen = 0;
  int window_writes = 0;
  int input_held = 0;

  always #2 clk = ~clk;

  pps_phase_offset_meter u_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .source_index_i      (in_src),
    .stamp_seconds_i     (in_sec),
    .stamp_nanoseconds_i (in_ns),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .result_source_o     (res_src),
    .status_o            (res_status),
    .phase_offset_ns_o   (res_offset),
    .offset_ready_o      (res_ready),
    .last_result_o       (res_last)
  );

  task automatic report_mismatch(string what, longint want, longint got);
    errors++;
    $display("%0t ns: mismatch on %s, expected %0d, got %0d", $time, what, want, got);
  endtask

  function automatic void clear_predictor();
    for (int i = 0; i <= NUM_SOURCES; i++) begin
      held_sec[i] = '0;
      held_ns[i] = '0;
      held_valid[i] = 1'b0;
    end
    for (int i = 0; i < NUM_SOURCES; i++) begin
      kept_offset[i] = '0;
      kept_ready[i] = 1'b0;
    end
    window = WINDOW_RESET;
  endfunction

  // Re-evaluate one external source against the reference; return 0 when
  // either stamp is still missing.
  function automatic bit judge_source(int s, output status_e st);
    longint gap;
    longint off;
    longint mag;
    st = STAT_UPDATED;
    if (!(held_valid[REF_SRC] && held_valid[s])) return 1'b0;
    gap = longint'(held_sec[s]) - longint'(held_sec[REF_SRC]);
    // treat a wide seconds gap as out of window before any scaling
    if (gap > 3 || gap < -3) begin
      kept_ready[s] = 1'b0;
      st = STAT_OUT_OF_WINDOW;
      return 1'b1;
    end
    off = gap * 64'sd1000000000 + longint'(held_ns[s]) - longint'(held_ns[REF_SRC]);
    mag = (off < 0) ? -off : off;
    if (mag > longint'(window)) begin
      kept_ready[s] = 1'b0;
      st = STAT_OUT_OF_WINDOW;
    end else begin
      kept_offset[s] = OFF_W'(off);
      kept_ready[s] = 1'b1;
    end
    return 1'b1;
  endfunction

  // Work out the reports that one accepted stamp request causes.
  function automatic void predict_stamp(logic [SRC_W-1:0] idx, logic [SEC_W-1:0] sec,
                                        logic [NS_W-1:0] ns);
    offset_report_t batch[$];
    offset_report_t r;
    status_e st;
    int lo;
    int hi;
    r.src = idx;
    r.offset = '0;
    r.ready = 1'b0;
    r.last = 1'b1;
    if (sec[SEC_W-1]) begin
      // negative seconds wins over an unknown index
      r.status = STAT_NEG_SECONDS;
      reports_due.push_back(r);
      return;
    end
    if (int'(idx) > REF_SRC) begin
      r.status = STAT_UNKNOWN_SRC;
      reports_due.push_back(r);
      return;
    end
    held_sec[idx] = sec;
    held_ns[idx] = ns;
    held_valid[idx] = 1'b1;
    lo = (int'(idx) == REF_SRC) ? 0 : int'(idx);
    hi = (int'(idx) == REF_SRC) ? NUM_SOURCES - 1 : int'(idx);
    for (int s = lo; s <= hi; s++) begin
      if (judge_source(s, st)) begin
        r.src = SRC_W'(s);
        r.status = st;
        r.offset = kept_offset[s];
        r.ready = kept_ready[s];
        r.last = 1'b0;
        batch.push_back(r);
      end
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) reports_due.push_back(batch[i]);
  endfunction

  // Offer one stamp request and hold it until the meter takes it. Valid is
  // left high when the next request follows with no gap.
  task automatic send_stamp(logic [SRC_W-1:0] idx, logic [SEC_W-1:0] sec,
                            logic [NS_W-1:0] ns);
    repeat (next_gap) @(posedge clk);
    in_valid <= 1'b1;
    in_src <= idx;
    in_sec <= sec;
    in_ns <= ns;
    valid_up = 1'b1;
    @(posedge clk);
    while (in_stall) begin
      input_held++;
      @(posedge clk);
    end
    predict_stamp(idx, sec, ns);
    requests_sent++;
    if (int'(idx) == REF_SRC) ref_requests++;
    next_gap = no_idle ? 0 : $urandom_range(0, 8);
    if (next_gap > 0) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  // Drop valid, wait for every owed report, then let a walk with no
  // results run out.
  task automatic settle_meter();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
    while (reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(logic [NS_W-1:0] w);
    settle_meter();
    cfg_valid <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    window = w;
    window_writes++;
  endtask

  function automatic logic [SEC_W-1:0] pick_seconds();
    int r;
    longint d;
    r = $urandom_range(0, 9);
    if (r <= 5) d = 0;
    else if (r == 6) d = 1;
    else if (r == 7) d = -1;
    else if (r == 8) d = longint'($urandom_range(2, 3));
    else d = longint'($urandom_range(4, 1000000));
    if (r >= 8 && $urandom_range(0, 1) == 0) d = -d;
    return sec_base + SEC_W'(d);
  endfunction

  // Nanoseconds mostly close to the reference, so offsets straddle the window.
  function automatic logic [NS_W-1:0] pick_nanoseconds();
    int r;
    longint span;
    longint v;
    r = $urandom_range(0, 4);
    if (r == 0) return NS_W'($urandom_range(0, 999999999));
    if (r == 1) begin
      case ($urandom_range(0, 2))
        0: return '0;
        1: return NS_TOP;
        default: return NS_ONES;
      endcase
    end
    span = longint'(window) + 2;
    if (span > 1000000000) span = 1000000000;
    v = longint'(held_ns[REF_SRC]) + longint'($urandom_range(0, 32'(2 * span))) - span;
    if (v < 0) v = 0;
    if (v > 999999999) v = 999999999;
    return NS_W'(v);
  endfunction

  // Mostly well-formed stamps around a shared second, with some noise,
  // negative seconds and unknown sources mixed in.
  task automatic send_random_stamp();
    int r;
    logic [SRC_W-1:0] idx;
    logic [SEC_W-1:0] sec;
    logic [NS_W-1:0] ns;
    if ($urandom_range(0, 39) == 0) begin
      if ($urandom_range(0, 1) == 0) sec_base = SEC_W'($urandom_range(0, 1000));
      else sec_base = {1'b0, (SEC_W-1)'({$urandom, $urandom})};
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      idx = SRC_W'($urandom);
      sec = SEC_W'({$urandom, $urandom});
      ns = NS_W'($urandom);
    end else if (r < 13) begin
      idx = SRC_W'($urandom);
      sec = SEC_W'({$urandom, $urandom}) | SEC_NEG_MIN;
      ns = NS_W'($urandom);
    end else if (r < 17) begin
      idx = SRC_W'($urandom_range(REF_SRC + 1, 7));
      sec = pick_seconds();
      ns = pick_nanoseconds();
    end else begin
      if ($urandom_range(0, 3) == 0) idx = SRC_W'(REF_SRC);
      else idx = SRC_W'($urandom_range(0, NUM_SOURCES - 1));
      sec = pick_seconds();
      ns = pick_nanoseconds();
    end
    send_stamp(idx, sec, ns);
  endtask

  // Receiver: take each result, check it against the oldest owed report,
  // then hold off for a drawn number of cycles. A long hold-off requested
  // by a test is counted down here as well.
  task automatic take_result();
    offset_report_t want;
    results_seen++;
    if (reports_due.size() == 0) begin
      report_mismatch("unrequested result from source", -1, longint'(res_src));
      return;
    end
    want = reports_due.pop_front();
    case (want.status)
      STAT_UPDATED: updated_seen++;
      STAT_OUT_OF_WINDOW: out_window_seen++;
      default: rejects_seen++;
    endcase
    if (res_src !== want.src)
      report_mismatch("result_source", longint'(want.src), longint'(res_src));
    if (res_status !== want.status)
      report_mismatch("status", longint'(want.status), longint'(res_status));
    if (res_offset !== want.offset)
      report_mismatch("phase_offset_ns", longint'(want.offset), longint'(res_offset));
    if (res_ready !== want.ready)
      report_mismatch("offset_ready", longint'(want.ready), longint'(res_ready));
    if (res_last !== want.last)
      report_mismatch("last_result", longint'(want.last), longint'(res_last));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      take_result();
      stall_left = no_idle ? 0 : $urandom_range(0, 8);
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Field extremes, every status and each corner of the offset arithmetic.
  task automatic test_directed();
    send_stamp(3'd0, SEC_W'(10), NS_W'(100));            // no reference yet: silent
    send_stamp(SRC_W'(REF_SRC), SEC_W'(10), '0);         // first reference walk
    send_stamp(3'd1, SEC_W'(10), NS_TOP);                // beyond window by ns
    send_stamp(3'd2, SEC_W'(11), '0);                    // one second ahead
    send_stamp(3'd2, SEC_W'(9), NS_TOP);                 // borrow across seconds
    send_stamp(3'd3, SEC_W'(14), '0);                    // wide gap ahead
    send_stamp(3'd4, SEC_W'(6), '0);                     // wide gap behind
    send_stamp(3'd3, SEC_W'(13), NS_ONES);               // three seconds, ns over range
    send_stamp(3'd0, SEC_W'(10), WINDOW_RESET);          // exactly on the window edge
    send_stamp(3'd0, SEC_W'(10), WINDOW_RESET + 1'b1);   // just past it
    send_stamp(SRC_W'(REF_SRC), SEC_TOP, NS_TOP);        // reference at the top second
    send_stamp(3'd0, SEC_TOP, NS_ONES);
    send_stamp(3'd4, '0, '0);                            // gap overflowing any scale
    send_stamp(3'd6, '0, '0);                            // unknown sources
    send_stamp(3'd7, SEC_W'(5), NS_ONES);
    send_stamp(3'd3, '1, '0);                            // negative seconds
    send_stamp(3'd7, SEC_NEG_MIN, NS_TOP);               // negative beats unknown
    set_window('0);
    send_stamp(SRC_W'(REF_SRC), '0, '0);
    send_stamp(3'd1, '0, '0);                            // zero offset, zero window
    send_stamp(3'd2, '0, NS_W'(1));                      // keeps the old offset
    set_window(NS_ONES);
    send_stamp(3'd3, SEC_W'(1), NS_W'(73741823));        // on the widest window
    send_stamp(3'd3, SEC_W'(1), NS_W'(73741824));
    send_stamp(SRC_W'(REF_SRC), SEC_W'(1), '0);
  endtask

  task automatic test_window_sweep();
    logic [NS_W-1:0] settings [4];
    settings[0] = NS_TOP;
    settings[1] = NS_W'(1000);
    settings[2] = NS_W'(1);
    settings[3] = NS_W'($urandom_range(0, 999999999));
    sec_base = SEC_W'(5000);
    foreach (settings[i]) begin
      set_window(settings[i]);
      repeat (20) send_random_stamp();
    end
  endtask

  // Hold the receiver off while requests keep coming, every third from the
  // reference, so the output stage fills and the input stalls.
  task automatic test_back_pressure();
    set_window(WINDOW_RESET);
    no_idle = 1'b1;
    next_gap = 0;
    hold_cycles = 150;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 0) send_stamp(SRC_W'(REF_SRC), sec_base, pick_nanoseconds());
      else send_stamp(SRC_W'(i % NUM_SOURCES), pick_seconds(), pick_nanoseconds());
    end
    settle_meter();
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    logic [NS_W-1:0] w;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: w = WINDOW_RESET;
        1: w = NS_W'($urandom_range(0, 1023));
        2: w = NS_W'($urandom_range(1, 999999999));
        3: w = NS_ONES;
        default: w = NS_TOP;
      endcase
      set_window(w);
      // run one phase back to back on both sides
      no_idle = (phase == 2);
      repeat (47) send_random_stamp();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    clear_predictor();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_window_sweep();
    test_back_pressure();
    test_random_traffic();
    settle_meter();
    $display("Sent %0d stamp requests (%0d from the reference) across %0d window settings.",
             requests_sent, ref_requests, window_writes);
    $display("Checked %0d results: %0d updated, %0d out of window, %0d rejected;",
             results_seen, updated_seen, out_window_seen, rejects_seen);
    $display("input held %0d cycles.", input_held);
    if (errors == 0) begin
      $display("PASS pps_phase_offset_meter");
    end else begin
      $display("FAIL pps_phase_offset_meter");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Timed out with %0d reports still owed.", reports_due.size());
    $display("FAIL pps_phase_offset_meter");
    $finish;
  end

endmodule
